FILE: hdl/upf_pkg.sv
// upf_pkg: shared types, constants and decode functions of the utf-8 punctuation filter
// no dependencies
`timescale 1ns / 1ps

package upf_pkg;

  // bytes in one decode group: up to three held bytes plus the new one
  localparam int unsigned GroupBytes = 4;
  localparam int unsigned HeldBytes  = GroupBytes - 1;

  // payload masks of lead and continuation bytes
  localparam logic [7:0] MaskLead2 = 8'h1F;
  localparam logic [7:0] MaskLead3 = 8'h0F;
  localparam logic [7:0] MaskLead4 = 8'h07;
  localparam logic [7:0] MaskCont  = 8'h3F;

  // code point width of a four-byte sequence
  localparam int unsigned CpWidth = 21;

  // unicode punctuation ranges
  localparam logic [CpWidth-1:0] GenPunctLo  = 21'h02010;
  localparam logic [CpWidth-1:0] GenPunctHi  = 21'h0205E;
  localparam logic [CpWidth-1:0] SupPunctLo  = 21'h02E00;
  localparam logic [CpWidth-1:0] SupPunctHi  = 21'h02E7F;
  localparam logic [CpWidth-1:0] CjkPunctLo  = 21'h03001;
  localparam logic [CpWidth-1:0] CjkPunctHi  = 21'h0303F;
  localparam logic [CpWidth-1:0] SmallFormLo = 21'h0FE50;
  localparam logic [CpWidth-1:0] SmallFormHi = 21'h0FE6F;

  // group handed from the decoder to the output buffer
  typedef struct packed {
    logic [GroupBytes-1:0]      keep;
    logic [GroupBytes-1:0][7:0] bytes;
    logic                       last;
  } upf_load_t;

  // sequence length set by a lead byte
  function automatic logic [2:0] lead_length(logic [7:0] b);
    logic [2:0] l;
    l = 3'd1;
    if (b >= 8'hC0 && b <= 8'hDF) l = 3'd2;
    if (b >= 8'hE0 && b <= 8'hEF) l = 3'd3;
    if (b >= 8'hF0 && b <= 8'hF7) l = 3'd4;
    return l;
  endfunction

  function automatic logic in_range(logic [CpWidth-1:0] cp, logic [CpWidth-1:0] lo,
                                    logic [CpWidth-1:0] hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  // ascii ispunct, latin-1 points and the fixed unicode blocks
  function automatic logic is_punct(logic [CpWidth-1:0] cp);
    logic p;
    p = 1'b0;
    if (in_range(cp, 21'h21, 21'h2F) || in_range(cp, 21'h3A, 21'h40) ||
        in_range(cp, 21'h5B, 21'h60) || in_range(cp, 21'h7B, 21'h7E)) p = 1'b1;
    if (cp == 21'hA1 || cp == 21'hA7 || cp == 21'hAB || cp == 21'hB6 ||
        cp == 21'hB7 || cp == 21'hBB || cp == 21'hBF) p = 1'b1;
    if (in_range(cp, GenPunctLo, GenPunctHi)) p = 1'b1;
    if (in_range(cp, SupPunctLo, SupPunctHi)) p = 1'b1;
    if (in_range(cp, CjkPunctLo, CjkPunctHi)) p = 1'b1;
    if (in_range(cp, SmallFormLo, SmallFormHi)) p = 1'b1;
    if (in_range(cp, 21'hFF01, 21'hFF0F) || in_range(cp, 21'hFF1A, 21'hFF20) ||
        in_range(cp, 21'hFF3B, 21'hFF40) || in_range(cp, 21'hFF5B, 21'hFF65)) p = 1'b1;
    return p;
  endfunction

endpackage

FILE: hdl/upf_if.sv
// upf_in_if, upf_out_if: valid/ready channels of the punctuation filter
// no dependencies
`timescale 1ns / 1ps

interface upf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface upf_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output byte_valid, output out_byte, output run_last,
                  output string_end, input ready);
  modport sink (input valid, input byte_valid, input out_byte, input run_last,
                input string_end, output ready);
endinterface

FILE: hdl/upf_decode.sv
// upf_decode: combinational decode and classification of one byte group
// depends on upf_pkg
`timescale 1ns / 1ps

module upf_decode (
  input  logic [upf_pkg::HeldBytes-1:0][7:0] held_i,
  input  logic [1:0]                         held_cnt_i,
  input  logic [7:0]                         in_byte_i,
  input  logic                               in_last_i,
  output logic                               hold_o,
  output upf_pkg::upf_load_t                 load_o
);
  import upf_pkg::*;

  localparam int unsigned ExtBytes = 2 * GroupBytes - 1;

  logic [ExtBytes-1:0][7:0]       ext;
  logic [2:0]                     n;
  logic [GroupBytes-1:0][2:0]     len;
  logic [GroupBytes-1:0]          punct;
  logic [GroupBytes-1:0][CpWidth-1:0] cp;
  logic [2:0]                     rem;
  logic                           cur_keep;
  logic [2:0]                     lead_l;

  // assemble the group, zero padded so every lookahead index exists
  always_comb begin
    ext = '0;
    for (int j = 0; j < HeldBytes; j++) begin
      if (j < int'(held_cnt_i)) ext[j] = held_i[j];
    end
    ext[{1'b0, held_cnt_i}] = in_byte_i;
  end

  assign n      = {1'b0, held_cnt_i} + 3'd1;
  assign hold_o = !in_last_i && (n < lead_length(ext[0]));

  // decode a code point at each start position, truncated leads stand alone
  always_comb begin
    for (int i = 0; i < GroupBytes; i++) begin
      lead_l = lead_length(ext[i]);
      len[i] = ((3'(i) + lead_l) <= n) ? lead_l : 3'd1;
      case (len[i])
        3'd2: cp[i] = {10'b0, ext[i][4:0] & MaskLead2[4:0], ext[i+1][5:0] & MaskCont[5:0]};
        3'd3: cp[i] = {5'b0, ext[i][3:0] & MaskLead3[3:0], ext[i+1][5:0] & MaskCont[5:0],
                       ext[i+2][5:0] & MaskCont[5:0]};
        3'd4: cp[i] = {ext[i][2:0] & MaskLead4[2:0], ext[i+1][5:0] & MaskCont[5:0],
                       ext[i+2][5:0] & MaskCont[5:0], ext[i+3][5:0] & MaskCont[5:0]};
        default: cp[i] = {13'b0, ext[i]};
      endcase
      punct[i] = is_punct(cp[i]);
    end
  end

  // walk the sequences left to right and mark the kept bytes
  always_comb begin
    load_o.bytes = ext[GroupBytes-1:0];
    load_o.last  = in_last_i;
    rem          = 3'd0;
    cur_keep     = 1'b0;
    for (int j = 0; j < GroupBytes; j++) begin
      if (rem == 3'd0) begin
        rem      = len[j];
        cur_keep = !punct[j];
      end
      load_o.keep[j] = cur_keep && (3'(j) < n);
      rem            = rem - 3'd1;
    end
  end

endmodule

FILE: hdl/upf_out_buf.sv
// upf_out_buf: result register that hands out the kept bytes of one group in order
// depends on upf_pkg, upf_if
`timescale 1ns / 1ps

module upf_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  upf_pkg::upf_load_t load_data_i,
  output logic               free_o,
  upf_out_if.source          out_o
);
  import upf_pkg::*;

  logic [GroupBytes-1:0]      mask_q, mask_d;
  logic                       marker_q, marker_d;
  logic                       last_q;
  logic [GroupBytes-1:0][7:0] bytes_q;
  logic [GroupBytes-1:0]      low_bit;
  logic                       single;
  logic                       fire;
  logic [7:0]                 sel_byte;

  // lowest kept byte goes out first
  assign low_bit = mask_q & (~mask_q + 4'd1);
  assign single  = (mask_q != '0) && ((mask_q & (mask_q - 4'd1)) == '0);

  always_comb begin
    sel_byte = 8'h00;
    for (int j = 0; j < GroupBytes; j++) begin
      if (low_bit[j]) sel_byte = bytes_q[j];
    end
  end

  // drive the result transaction
  always_comb begin
    out_o.valid      = (mask_q != '0) || marker_q;
    out_o.byte_valid = (mask_q != '0);
    out_o.out_byte   = (mask_q != '0) ? sel_byte : 8'h00;
    out_o.run_last   = single || (mask_q == '0);
    out_o.string_end = last_q && (single || (mask_q == '0));
  end

  assign fire   = out_o.valid && out_o.ready;
  assign free_o = !out_o.valid || (fire && out_o.run_last);

  // next buffer contents
  always_comb begin
    mask_d   = mask_q;
    marker_d = marker_q;
    if (fire) begin
      mask_d   = mask_q & ~low_bit;
      marker_d = 1'b0;
    end
    if (load_i) begin
      mask_d   = load_data_i.keep;
      marker_d = load_data_i.last && (load_data_i.keep == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      marker_q <= 1'b0;
    end else begin
      mask_q   <= mask_d;
      marker_q <= marker_d;
    end
  end

  // payload of the group
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= load_data_i.bytes;
      last_q  <= load_data_i.last;
    end
  end

endmodule

FILE: hdl/utf8_punctuation_filter.sv
// utf8_punctuation_filter: drops utf-8 punctuation sequences from a byte stream
// depends on upf_pkg, upf_if, upf_decode, upf_out_buf
// The first result is registered and appears in the cycle after the byte that completes a sequence is accepted.
// Throughput: one byte per cycle while the output is ready and each group yields at most
// one result; k kept bytes hold the output register and the input waits for the last.
// Reset clears the held byte count and the output register; no clearing pass is needed.
`timescale 1ns / 1ps

module utf8_punctuation_filter (
  input  logic     clk_i,
  input  logic     rst_ni,
  upf_in_if.sink   in_i,
  upf_out_if.source out_o
);
  import upf_pkg::*;

  logic [HeldBytes-1:0][7:0] held_q;
  logic [1:0]                cnt_q, cnt_d;
  logic                      hold;
  logic                      free;
  logic                      in_fire;
  upf_load_t                 load;

  // decode the held bytes together with the incoming one
  upf_decode u_decode (
    .held_i     (held_q),
    .held_cnt_i (cnt_q),
    .in_byte_i  (in_i.in_byte),
    .in_last_i  (in_i.in_last),
    .hold_o     (hold),
    .load_o     (load)
  );

  upf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire && !hold),
    .load_data_i (load),
    .free_o      (free),
    .out_o       (out_o)
  );

  assign in_i.ready = free;
  assign in_fire    = in_i.valid && in_i.ready;

  // held byte count of an unfinished sequence
  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) cnt_d = hold ? (cnt_q + 2'd1) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // held bytes, only read below the count
  always_ff @(posedge clk_i) begin
    if (in_fire && hold) held_q[cnt_q] <= in_i.in_byte;
  end

endmodule

FILE: sim/utf8_punctuation_filter_tb.sv
// utf8_punctuation_filter_tb: self-checking bench for the utf-8 punctuation filter
// drives byte strings through the input channel and checks every output transaction
// depends on upf_pkg, upf_if and utf8_punctuation_filter
`timescale 1ns / 1ps

module utf8_punctuation_filter_tb;

  import upf_pkg::*;

  localparam int unsigned IdlePct     = 21;
  localparam int unsigned RandomBytes = 444;
  localparam int unsigned DirectedRows = 26;
  localparam int unsigned PunctSpans  = 19;
  localparam int unsigned CalmFirst   = 250;
  localparam int unsigned CalmLast    = 350;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PrintCap    = 40;

  // how a stimulus row gets its expectation
  typedef enum logic [1:0] {
    RowPredicted, // computed by the filter predictor
    RowNone,      // no output transaction
    RowEcho,      // the byte comes back alone
    RowMarker     // bare end marker
  } row_kind_e;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } upf_result_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
    row_kind_e  kind;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  upf_in_if  in_ch ();
  upf_out_if out_ch ();

  utf8_punctuation_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stim_t       stim_q[$];
  upf_result_t filtered_q[$];
  logic [7:0]  str_q[$];

  // predictor state: bytes of an unfinished sequence
  logic [7:0]  held [3];
  int unsigned held_n;
  upf_result_t pred_res [4];
  int unsigned pred_n;

  int unsigned cycle;
  int unsigned accepted;
  int unsigned mismatches;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PrintCap) $display("mismatch at cycle %0d: %s", cycle, msg);
  endtask

  // bytes in the sequence that a lead byte opens
  function automatic int unsigned seq_bytes(logic [7:0] b);
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 1;
  endfunction

  // punctuation spans as {lo, hi}
  function automatic logic [41:0] punct_span(int unsigned idx);
    case (idx)
      0:  return {21'h00021, 21'h0002F};
      1:  return {21'h0003A, 21'h00040};
      2:  return {21'h0005B, 21'h00060};
      3:  return {21'h0007B, 21'h0007E};
      4:  return {21'h000A1, 21'h000A1};
      5:  return {21'h000A7, 21'h000A7};
      6:  return {21'h000AB, 21'h000AB};
      7:  return {21'h000B6, 21'h000B7};
      8:  return {21'h000BB, 21'h000BB};
      9:  return {21'h000BF, 21'h000BF};
      10: return {21'h02010, 21'h0205E};
      11: return {21'h02E00, 21'h02E7F};
      12: return {21'h03001, 21'h0303F};
      13: return {21'h0FE50, 21'h0FE6F};
      14: return {21'h0FF01, 21'h0FF0F};
      15: return {21'h0FF1A, 21'h0FF20};
      16: return {21'h0FF3B, 21'h0FF40};
      17: return {21'h0FF5B, 21'h0FF65};
      default: return {21'h000B6, 21'h000B6};
    endcase
  endfunction

  function automatic logic punct_cp(logic [20:0] cp);
    logic [41:0] s;
    logic        hit;
    int unsigned i;
    hit = 1'b0;
    for (i = 0; i < PunctSpans; i++) begin
      s = punct_span(i);
      if (cp >= s[41:21] && cp <= s[20:0]) hit = 1'b1;
    end
    return hit;
  endfunction

  // filter predictor: takes one accepted byte, leaves its results in pred_res
  task automatic filter_byte(input logic [7:0] b, input logic last);
    logic [7:0]  grp [4];
    logic [20:0] cp;
    int unsigned n, i, j, len;
    for (i = 0; i < held_n; i++) grp[i] = held[i];
    grp[held_n] = b;
    n = held_n + 1;
    pred_n = 0;
    if (!last && n < seq_bytes(grp[0])) begin
      // still collecting the sequence
      for (i = 0; i < n; i++) held[i] = grp[i];
      held_n = n;
    end else begin
      // walk the group; leads that no longer fit stand alone
      i = 0;
      while (i < n) begin
        len = seq_bytes(grp[i]);
        if (i + len > n) len = 1;
        case (len)
          2: cp = {10'd0, grp[i][4:0], grp[i+1][5:0]};
          3: cp = {5'd0, grp[i][3:0], grp[i+1][5:0], grp[i+2][5:0]};
          4: cp = {grp[i][2:0], grp[i+1][5:0], grp[i+2][5:0], grp[i+3][5:0]};
          default: cp = {13'd0, grp[i]};
        endcase
        if (!punct_cp(cp)) begin
          for (j = 0; j < len; j++) begin
            pred_res[pred_n] = {1'b1, grp[i+j], 2'b00};
            pred_n++;
          end
        end
        i += len;
      end
      held_n = 0;
      for (i = 0; i < 3; i++) held[i] = 8'h00;
      // bare end marker when the string closes with nothing kept
      if (last && pred_n == 0) begin
        pred_res[0] = {1'b0, 8'h00, 2'b00};
        pred_n = 1;
      end
      if (pred_n > 0) begin
        pred_res[pred_n-1].run_last = 1'b1;
        pred_res[pred_n-1].string_end = last;
      end
    end
  endtask

  function automatic stim_t row(logic [7:0] b, logic l, row_kind_e k);
    stim_t s;
    s.in_byte = b;
    s.in_last = l;
    s.kind = k;
    return s;
  endfunction

  // directed strings: extremes, overlong, stray bytes, cut sequences, end markers
  function automatic stim_t directed_row(int unsigned idx);
    case (idx)
      0:  return row(8'h41, 1'b0, RowEcho);      // plain letter
      1:  return row(8'h21, 1'b0, RowNone);      // ascii punctuation dropped
      2:  return row(8'h00, 1'b0, RowEcho);      // lowest byte
      3:  return row(8'h7E, 1'b1, RowMarker);    // string ends on punctuation
      4:  return row(8'hC0, 1'b0, RowNone);      // overlong exclamation mark
      5:  return row(8'hA1, 1'b0, RowNone);
      6:  return row(8'hC3, 1'b0, RowNone);      // two-byte letter kept
      7:  return row(8'hA9, 1'b1, RowPredicted);
      8:  return row(8'hE2, 1'b0, RowNone);      // em dash dropped
      9:  return row(8'h80, 1'b0, RowNone);
      10: return row(8'h94, 1'b0, RowNone);
      11: return row(8'hF0, 1'b0, RowNone);      // four-byte emoji kept
      12: return row(8'h9F, 1'b0, RowNone);
      13: return row(8'h98, 1'b0, RowNone);
      14: return row(8'h80, 1'b1, RowPredicted);
      15: return row(8'hC2, 1'b0, RowNone);      // inverted question mark
      16: return row(8'hBF, 1'b0, RowNone);
      17: return row(8'h5A, 1'b1, RowEcho);
      18: return row(8'hE3, 1'b0, RowNone);      // three-byte lead cut by the end
      19: return row(8'h80, 1'b1, RowPredicted);
      20: return row(8'hF7, 1'b0, RowNone);      // cut lead, inner sequence still fits
      21: return row(8'hC2, 1'b0, RowNone);
      22: return row(8'hA1, 1'b1, RowPredicted);
      23: return row(8'h80, 1'b1, RowEcho);      // stray continuation as lead
      24: return row(8'hFF, 1'b1, RowEcho);      // highest byte
      default: return row(8'hF8, 1'b0, RowEcho);
    endcase
  endfunction

  // encode a code point in a forced form; forms longer than needed give overlong sequences
  task automatic push_form(input logic [20:0] cp, input int unsigned len);
    case (len)
      1: str_q.push_back(cp[7:0]);
      2: begin
        str_q.push_back({3'b110, cp[10:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_q.push_back({4'b1110, cp[15:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_q.push_back({5'b11110, cp[20:18]});
        str_q.push_back({2'b10, cp[17:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // one random string: mostly well-formed sequences, some noise and cut tails
  task automatic add_random_string();
    logic [41:0] span;
    logic [20:0] cp;
    int unsigned seqs, s, pick, k, extra;
    str_q.delete();
    seqs = $urandom_range(1, 8);
    for (s = 0; s < seqs; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        push_form(21'($urandom_range(0, 127)), 1);
      end else if (pick < 42) begin
        push_form(21'($urandom_range(0, 21'h7FF)), 2);
      end else if (pick < 56) begin
        push_form(21'($urandom_range(0, 21'hFFFF)), 3);
      end else if (pick < 64) begin
        push_form(21'($urandom_range(0, 21'h1FFFFF)), 4);
      end else if (pick < 84) begin
        // near or inside a punctuation span, shortest form
        span = punct_span($urandom_range(0, PunctSpans - 1));
        case ($urandom_range(0, 3))
          0: cp = span[41:21] - 21'd1;
          1: cp = span[41:21];
          2: cp = span[20:0] + 21'd1;
          default: cp = 21'($urandom_range(span[41:21], span[20:0]));
        endcase
        if (cp < 21'h80) push_form(cp, 1);
        else if (cp < 21'h800) push_form(cp, 2);
        else if (cp < 21'h10000) push_form(cp, 3);
        else push_form(cp, 4);
      end else if (pick < 92) begin
        // lead with raw trailing bytes of any value
        str_q.push_back(8'($urandom_range(8'hC0, 8'hF7)));
        extra = $urandom_range(1, 3);
        for (k = 0; k < extra; k++) str_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        str_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    // end the string inside a sequence now and then
    if (str_q.size() > 1 && $urandom_range(0, 99) < 15) void'(str_q.pop_back());
    for (k = 0; k < str_q.size(); k++)
      stim_q.push_back(row(str_q[k], k == str_q.size() - 1, RowPredicted));
  endtask

  // compare one output transaction with the oldest expectation
  task automatic check_result();
    upf_result_t got, want;
    got = {out_ch.byte_valid, out_ch.out_byte, out_ch.run_last, out_ch.string_end};
    if (filtered_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction %h", got));
    end else begin
      want = filtered_q.pop_front();
      if (got.byte_valid !== want.byte_valid)
        report_mismatch($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
      if (got.run_last !== want.run_last)
        report_mismatch($sformatf("run_last %b, want %b", got.run_last, want.run_last));
      if (got.string_end !== want.string_end)
        report_mismatch($sformatf("string_end %b, want %b", got.string_end, want.string_end));
    end
  endtask

  initial begin
    stim_t       cur;
    upf_result_t r;
    int unsigned total, drain, i;
    logic        calm;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    held_n = 0;
    for (i = 0; i < 3; i++) held[i] = 8'h00;
    cycle = 0;
    accepted = 0;
    mismatches = 0;
    drain = 0;
    cur = row(8'h00, 1'b0, RowNone);

    // build the whole stimulus: directed table, then random strings
    for (i = 0; i < DirectedRows; i++) stim_q.push_back(directed_row(i));
    while (stim_q.size() < DirectedRows + RandomBytes) add_random_string();
    total = stim_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (drain < DrainCycles && cycle < CycleLimit) begin
      @(posedge clk_i);
      cycle++;
      calm = (accepted >= CalmFirst) && (accepted < CalmLast);

      // input transaction: predict what it causes
      if (in_ch.valid && in_ch.ready) begin
        filter_byte(cur.in_byte, cur.in_last);
        case (cur.kind)
          RowPredicted: for (i = 0; i < pred_n; i++) filtered_q.push_back(pred_res[i]);
          RowEcho: begin
            r = {1'b1, cur.in_byte, 1'b1, cur.in_last};
            filtered_q.push_back(r);
          end
          RowMarker: begin
            r = {1'b0, 8'h00, 1'b1, 1'b1};
            filtered_q.push_back(r);
          end
          default: ;
        endcase
        accepted++;
      end

      if (out_ch.valid && out_ch.ready) check_result();

      // next input byte, with random gaps
      if (!in_ch.valid || in_ch.ready) begin
        if (stim_q.size() > 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          cur = stim_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= cur.in_byte;
          in_ch.in_last <= cur.in_last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end

      // random output stalls
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IdlePct);

      if (accepted == total && filtered_q.size() == 0) drain++;
      else drain = 0;
    end

    if (cycle >= CycleLimit) report_mismatch("timeout waiting for the filter");
    if (filtered_q.size() > 0)
      report_mismatch($sformatf("%0d expected transactions never came", filtered_q.size()));

    if (mismatches == 0) begin
      $display("utf8_punctuation_filter verification clean");
    end else begin
      $display("utf8_punctuation_filter verification failed");
    end
    $finish;
  end

endmodule
